// ----- hw/rtl/sot_pkg.sv -----
// Shared types, constants and helpers for the script opcode tokenizer.
package sot_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_OPCODE   = 1'd0,
        CFG_LENGTH_PREFIXED = 1'd1
    } cfg_index_t;

    // Opcode and prefix values
    localparam logic [7:0] BIG_LEN_MARK = 8'hFD;
    localparam logic [7:0] OP_SIZE1     = 8'h4C;
    localparam logic [7:0] OP_SIZE2     = 8'h4D;
    localparam logic [7:0] OP_SIZE4     = 8'h4E;
    localparam logic [7:0] OPCODE_NONE  = 8'hFF;

    // Result queue sizing: room for the two results one byte can cause
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef enum logic {
        KIND_OP  = 1'b0,
        KIND_END = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        END_OK         = 2'd0,
        END_TRUNCATED  = 2'd1,
        END_BAD_PREFIX = 2'd2
    } end_status_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [7:0]   opcode;
        logic [31:0]  op_index;
        logic [31:0]  data_offset;
        logic [31:0]  data_length;
        logic [31:0]  match_count;
        end_status_t  end_status;
        logic         last_of_run;
    } result_t;

    // Results produced by one byte, in delivery order
    typedef struct packed {
        logic [1:0] n;
        result_t    first;
        result_t    second;
    } push_t;

    // Number of little-endian length bytes after a PUSHDATA opcode
    function automatic logic [2:0] len_bytes(input logic [7:0] op);
        logic [2:0] nb;
        begin
            if (op == OP_SIZE1)
            begin
                nb = 3'd1;
            end
            else if (op == OP_SIZE2)
            begin
                nb = 3'd2;
            end
            else
            begin
                nb = 3'd4;
            end
            return nb;
        end
    endfunction

endpackage

// ----- hw/rtl/sot_in_if.sv -----
// Input channel: one script byte per item.
interface sot_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] script_byte;
    logic       last_byte;

    modport source (output valid, output script_byte, output last_byte, input ready);
    modport sink   (input valid, input script_byte, input last_byte, output ready);
endinterface

// ----- hw/rtl/sot_out_if.sv -----
// Output channel: one opcode or end-of-script report per item.
interface sot_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  opcode;
    logic [31:0] op_index;
    logic [31:0] data_offset;
    logic [31:0] data_length;
    logic [31:0] match_count;
    logic [1:0]  end_status;
    logic        last_of_run;

    modport source (
        output valid, output result_kind, output opcode, output op_index,
        output data_offset, output data_length, output match_count,
        output end_status, output last_of_run, input ready
    );
    modport sink (
        input valid, input result_kind, input opcode, input op_index,
        input data_offset, input data_length, input match_count,
        input end_status, input last_of_run, output ready
    );
endinterface

// ----- hw/rtl/sot_parser.sv -----
// Parse state and combinational per-byte step that builds the reports.
module sot_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          script_byte,
    input  logic                last_byte,
    input  logic [7:0]          target_opcode,
    input  logic                length_prefixed,
    output sot_pkg::push_t      push
);

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_PFX_LO = 7'b0000010,
        PH_PFX_HI = 7'b0000100,
        PH_OPCODE = 7'b0001000,
        PH_LEN    = 7'b0010000,
        PH_DATA   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] rem_reg, rem_next;
    logic [2:0]  lbl_reg, lbl_next;
    logic [7:0]  cur_op_reg, cur_op_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] ops_reg, ops_next;
    logic [31:0] matches_reg, matches_next;
    logic [15:0] decl_reg, decl_next;
    logic        perr_reg, perr_next;
    logic        limited_reg, limited_next;
    logic        trunc_reg, trunc_next;
    logic [31:0] data_len_reg, data_len_next;

    sot_pkg::result_t     op_res;
    sot_pkg::result_t     end_res;
    sot_pkg::end_status_t status;
    logic                 do_step;
    logic                 finish;
    logic [2:0]           lane_full;
    logic [1:0]           lane;

    // Next state and reports for the byte in the input register
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg + 32'd1;
        rem_next      = rem_reg;
        lbl_next      = lbl_reg;
        cur_op_next   = cur_op_reg;
        off_next      = off_reg;
        ops_next      = ops_reg;
        matches_next  = matches_reg;
        decl_next     = decl_reg;
        perr_next     = perr_reg;
        limited_next  = limited_reg;
        trunc_next    = trunc_reg;
        data_len_next = data_len_reg;
        do_step       = 1'b0;
        finish        = 1'b0;
        lane_full     = 3'd0;
        lane          = 2'd0;
        status        = sot_pkg::END_OK;
        op_res        = '0;
        end_res       = '0;

        // Prefix handling
        case (phase_reg)
            PH_START:
            begin
                if (length_prefixed)
                begin
                    limited_next = 1'b1;
                    if (script_byte < sot_pkg::BIG_LEN_MARK)
                    begin
                        decl_next  = {8'd0, script_byte};
                        phase_next = (script_byte != 8'd0) ? PH_OPCODE : PH_DONE;
                    end
                    else if (script_byte == sot_pkg::BIG_LEN_MARK)
                    begin
                        phase_next = PH_PFX_LO;
                    end
                    else
                    begin
                        perr_next  = 1'b1;
                        phase_next = PH_DONE;
                    end
                end
                else
                begin
                    limited_next = 1'b0;
                    phase_next   = PH_OPCODE;
                    do_step      = 1'b1;
                end
            end
            PH_PFX_LO:
            begin
                decl_next  = {8'd0, script_byte};
                phase_next = PH_PFX_HI;
            end
            PH_PFX_HI:
            begin
                decl_next  = {script_byte, decl_reg[7:0]};
                phase_next = ({script_byte, decl_reg[7:0]} != 16'd0) ? PH_OPCODE : PH_DONE;
            end
            PH_OPCODE, PH_LEN, PH_DATA:
            begin
                do_step = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Script byte: opcode, length byte or data byte
        if (do_step)
        begin
            if (limited_next)
            begin
                decl_next = decl_next - 16'd1;
            end
            case (phase_next)
                PH_OPCODE:
                begin
                    cur_op_next   = script_byte;
                    off_next      = 32'd0;
                    data_len_next = 32'd0;
                    rem_next      = 32'd0;
                    if (script_byte < sot_pkg::OP_SIZE1)
                    begin
                        data_len_next = {24'd0, script_byte};
                        rem_next      = {24'd0, script_byte};
                        if (script_byte == 8'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            off_next   = pos_reg + 32'd1;
                            phase_next = PH_DATA;
                        end
                    end
                    else if (script_byte <= sot_pkg::OP_SIZE4)
                    begin
                        lbl_next   = sot_pkg::len_bytes(script_byte);
                        phase_next = PH_LEN;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                PH_LEN:
                begin
                    lane_full = sot_pkg::len_bytes(cur_op_reg) - lbl_reg;
                    lane      = lane_full[1:0];
                    case (lane)
                        2'd0:    rem_next[7:0]   = rem_reg[7:0]   | script_byte;
                        2'd1:    rem_next[15:8]  = rem_reg[15:8]  | script_byte;
                        2'd2:    rem_next[23:16] = rem_reg[23:16] | script_byte;
                        default: rem_next[31:24] = rem_reg[31:24] | script_byte;
                    endcase
                    lbl_next = lbl_reg - 3'd1;
                    if (lbl_next == 3'd0)
                    begin
                        data_len_next = rem_next;
                        if (rem_next == 32'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            off_next   = pos_reg + 32'd1;
                            phase_next = PH_DATA;
                        end
                    end
                end
                default:
                begin
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == 32'd0)
                    begin
                        finish = 1'b1;
                    end
                end
            endcase

            // Opcode finished: count it and build its report
            if (finish)
            begin
                if (cur_op_next == target_opcode)
                begin
                    matches_next = matches_reg + 32'd1;
                end
                op_res.result_kind = sot_pkg::KIND_OP;
                op_res.opcode      = cur_op_next;
                op_res.op_index    = ops_reg;
                op_res.data_offset = off_next;
                op_res.data_length = data_len_next;
                op_res.match_count = matches_next;
                op_res.end_status  = sot_pkg::END_OK;
                op_res.last_of_run = ~last_byte;
                ops_next           = ops_reg + 32'd1;
                phase_next         = PH_OPCODE;
            end

            // Declared script length used up
            if (limited_next && (decl_next == 16'd0) && (phase_next != PH_DONE))
            begin
                if (phase_next != PH_OPCODE)
                begin
                    trunc_next = 1'b1;
                end
                phase_next = PH_DONE;
            end
        end

        // End of buffer: status report, then back to a fresh stream
        if (perr_next || (phase_next == PH_START) || (phase_next == PH_PFX_LO) ||
            (phase_next == PH_PFX_HI) ||
            (limited_next && (phase_next != PH_DONE) && (decl_next != 16'd0)))
        begin
            status = sot_pkg::END_BAD_PREFIX;
        end
        else if (trunc_next || (phase_next == PH_LEN) || (phase_next == PH_DATA))
        begin
            status = sot_pkg::END_TRUNCATED;
        end
        else
        begin
            status = sot_pkg::END_OK;
        end
        end_res.result_kind = sot_pkg::KIND_END;
        end_res.opcode      = sot_pkg::OPCODE_NONE;
        end_res.op_index    = ops_next;
        end_res.data_offset = 32'd0;
        end_res.data_length = 32'd0;
        end_res.match_count = matches_next;
        end_res.end_status  = status;
        end_res.last_of_run = 1'b1;

        if (last_byte)
        begin
            phase_next    = PH_START;
            pos_next      = 32'd0;
            rem_next      = 32'd0;
            lbl_next      = 3'd0;
            cur_op_next   = sot_pkg::OPCODE_NONE;
            off_next      = 32'd0;
            ops_next      = 32'd0;
            matches_next  = 32'd0;
            decl_next     = 16'd0;
            perr_next     = 1'b0;
            limited_next  = 1'b0;
            trunc_next    = 1'b0;
            data_len_next = 32'd0;
        end
    end

    // Results handed to the queue, opcode report first
    always_comb
    begin
        push = '0;
        if (fire)
        begin
            push.n = {1'b0, finish} + {1'b0, last_byte};
            if (finish)
            begin
                push.first  = op_res;
                push.second = end_res;
            end
            else
            begin
                push.first  = end_res;
                push.second = end_res;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            pos_reg      <= 32'd0;
            rem_reg      <= 32'd0;
            lbl_reg      <= 3'd0;
            cur_op_reg   <= sot_pkg::OPCODE_NONE;
            off_reg      <= 32'd0;
            ops_reg      <= 32'd0;
            matches_reg  <= 32'd0;
            decl_reg     <= 16'd0;
            perr_reg     <= 1'b0;
            limited_reg  <= 1'b0;
            trunc_reg    <= 1'b0;
            data_len_reg <= 32'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            rem_reg      <= rem_next;
            lbl_reg      <= lbl_next;
            cur_op_reg   <= cur_op_next;
            off_reg      <= off_next;
            ops_reg      <= ops_next;
            matches_reg  <= matches_next;
            decl_reg     <= decl_next;
            perr_reg     <= perr_next;
            limited_reg  <= limited_next;
            trunc_reg    <= trunc_next;
            data_len_reg <= data_len_next;
        end
    end

    // A buffer end always returns the parser to its start phase
    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> phase_reg == PH_START)
        else $error("parser did not restart after end of buffer");

    // Two results from one byte only when that byte ends the buffer
    a_two_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> fire && last_byte && push.second.result_kind == sot_pkg::KIND_END)
        else $error("second result without end of buffer");

endmodule

// ----- hw/rtl/sot_result_fifo.sv -----
// Small result queue between the parser and the output channel.
module sot_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  sot_pkg::push_t     push,
    input  logic               pop,
    output sot_pkg::result_t   head,
    output logic               not_empty,
    output logic               room
);

    sot_pkg::result_t entry_reg [sot_pkg::RES_DEPTH];

    logic [sot_pkg::RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sot_pkg::RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sot_pkg::RES_CNT_W-1:0] count_reg, count_next;
    logic [sot_pkg::RES_PTR_W-1:0] wr_ptr_plus1;

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    // Room for the worst case of two results from the next byte
    assign room      = (count_reg <= sot_pkg::RES_CNT_W'(sot_pkg::RES_DEPTH - 2));

    // Pointer and fill level updates
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + sot_pkg::RES_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + sot_pkg::RES_PTR_W'(push.n);
        rd_ptr_next  = rd_ptr_reg + sot_pkg::RES_PTR_W'(pop);
        count_next   = count_reg + sot_pkg::RES_CNT_W'(push.n) - sot_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sot_pkg::RES_CNT_W'(sot_pkg::RES_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> room)
        else $error("push into result queue without room");

endmodule

// ----- hw/rtl/script_opcode_tokenizer.sv -----
// Script opcode tokenizer: top level with input register, config and result queue.
//
// Takes one script byte per item and reports each finished opcode, plus an end
// report on the byte marked last_byte. A byte is taken every cycle while the
// queue has room: it sits in the input register, is parsed in a single pass that
// updates the parse state, and its results land at the next clock edge in a
// four-entry result queue, whose head drives the output channel directly. A byte
// causes zero, one or two results; the output delivers one result per cycle while
// the receiver is ready, so the sustained rate is one byte per cycle unless
// results pile up, in which case input stalls while the queue holds more than
// two results. Configuration writes take effect on the next clock edge and must
// only be issued while the block is idle.
module script_opcode_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sot_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sot_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    sot_in_if.sink                         script,
    sot_out_if.source                      result
);

    logic [7:0]       target_reg;
    logic             prefixed_reg;
    logic             in_valid_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             fire;
    logic             room;
    logic             not_empty;
    sot_pkg::push_t   push;
    sot_pkg::result_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= 8'd0;
            prefixed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (sot_pkg::cfg_index_t'(cfg_index))
                sot_pkg::CFG_TARGET_OPCODE:   target_reg   <= cfg_wdata[7:0];
                sot_pkg::CFG_LENGTH_PREFIXED: prefixed_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: parse when the queue can take a byte's results
    assign fire         = in_valid_reg & room;
    assign script.ready = ~in_valid_reg | fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (script.ready)
        begin
            in_valid_reg <= script.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (script.valid && script.ready)
        begin
            byte_reg <= script.script_byte;
            last_reg <= script.last_byte;
        end
    end

    sot_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (fire),
        .script_byte     (byte_reg),
        .last_byte       (last_reg),
        .target_opcode   (target_reg),
        .length_prefixed (prefixed_reg),
        .push            (push)
    );

    sot_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (result.valid & result.ready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    // Output channel
    assign result.valid       = not_empty;
    assign result.result_kind = head.result_kind;
    assign result.opcode      = head.opcode;
    assign result.op_index    = head.op_index;
    assign result.data_offset = head.data_offset;
    assign result.data_length = head.data_length;
    assign result.match_count = head.match_count;
    assign result.end_status  = head.end_status;
    assign result.last_of_run = head.last_of_run;

endmodule
